// ----- sv/lkvc_pkg.sv -----
// lkvc_pkg: shared types and constants for the lru key/value cache
// request and response payload structs, status codes, cell control struct
// no dependencies
`timescale 1ns / 1ps

package lkvc_pkg;

    // fixed field widths
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int CAP_BITS    = 5;

    // capacity register after reset
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // request opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // response status codes
    typedef enum logic [2:0] {
        ST_GET_HIT      = 3'd0,
        ST_GET_MISS     = 3'd1,
        ST_PUT_UPDATED  = 3'd2,
        ST_PUT_ADDED    = 3'd3,
        ST_PUT_REPLACED = 3'd4,
        ST_PUT_REJECTED = 3'd5
    } t_status;

    // request payload
    typedef struct packed {
        logic                          op;
        logic signed [KEY_BITS-1:0]    key;
        logic signed [VALUE_BITS-1:0]  write_value;
    } t_req;

    // response payload
    typedef struct packed {
        t_status                       status;
        logic signed [VALUE_BITS-1:0]  read_value;
        logic signed [KEY_BITS-1:0]    evicted_key;
    } t_rsp;

    // strobes from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;   // capture key match
        logic upd_en;   // shift toward older positions up to the target
    } t_cell_ctrl;

endpackage

// ----- sv/lru_key_value_cache_top.sv -----
// lru_key_value_cache_top: fully associative key/value cache, lru replacement
// chain of lkvc_cell positions ordered newest to oldest, plus sequencer
// depends on lkvc_pkg and lkvc_cell
//
//   channel   direction  handshake                    payload
//   request   in         i_valid / o_ready            i_req (op, key, write_value)
//   response  out        o_valid / i_ready            o_rsp (status, read_value, evicted_key)
//   config    in         i_cfg_wr_en, no wait         i_cfg_wr_data (capacity)
//
// a request passes three steps: accept, key compare in every cell, then update
// no new request is taken until the last one has finished its update step
// a result that is not taken holds the update step until the output frees up
// synchronous active-low reset empties the chain at once; no clearing pass
`timescale 1ns / 1ps

module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CAP_BITS-1:0]  i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_req                 i_req,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_rsp                 o_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    t_req                  r_req;
    logic [CAP_BITS-1:0]   r_cap;
    logic [CNT_W-1:0]      r_occ, n_occ;
    logic                  r_out_valid;
    t_rsp                  r_rsp, n_rsp;

    t_cell_ctrl            w_ctrl;
    logic [ENTRIES-1:0]    c_valid;
    logic [ENTRIES-1:0]    c_match;
    logic [ENTRIES-1:0]    c_sel;
    logic [KEY_BITS-1:0]   c_key   [ENTRIES];
    logic [VALUE_BITS-1:0] c_value [ENTRIES];

    logic                  w_hit;
    logic [IDX_W-1:0]      w_hit_idx;
    logic [IDX_W-1:0]      w_target;
    logic [CMP_W-1:0]      w_cap_eff;
    logic                  w_full;
    logic [KEY_BITS-1:0]   w_sel_key;
    logic [VALUE_BITS-1:0] w_sel_value;
    logic [KEY_BITS-1:0]   w_head_key;
    logic [VALUE_BITS-1:0] w_head_value;
    logic                  w_shift;
    logic                  w_upd_go;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    assign w_upd_go = (r_state == S_UPD) && (!r_out_valid || i_ready);

    assign w_ctrl.cmp_en = (r_state == S_CMP);
    assign w_ctrl.upd_en = w_upd_go && w_shift;

    // cell chain, position 0 is newest
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic                  w_pv;
        logic [KEY_BITS-1:0]   w_pk;
        logic [VALUE_BITS-1:0] w_pval;
        if (g == 0) begin : g_head
            assign w_pv   = 1'b1;
            assign w_pk   = w_head_key;
            assign w_pval = w_head_value;
        end else begin : g_link
            assign w_pv   = c_valid[g-1];
            assign w_pk   = c_key[g-1];
            assign w_pval = c_value[g-1];
        end
        lkvc_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_req_key    (r_req.key),
            .i_target     (w_target),
            .i_prev_valid (w_pv),
            .i_prev_key   (w_pk),
            .i_prev_value (w_pval),
            .o_valid      (c_valid[g]),
            .o_key        (c_key[g]),
            .o_value      (c_value[g]),
            .o_match      (c_match[g]),
            .o_sel        (c_sel[g])
        );
    end

    // hit position encode and target entry select
    always_comb begin
        w_hit_idx   = '0;
        w_sel_key   = '0;
        w_sel_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_idx   = w_hit_idx | (c_match[i] ? IDX_W'(i) : '0);
            w_sel_key   = w_sel_key | (c_sel[i] ? c_key[i] : '0);
            w_sel_value = w_sel_value | (c_sel[i] ? c_value[i] : '0);
        end
    end

    assign w_hit = |c_match;

    // capacity clamped to 1..ENTRIES; occupancy at or above it counts as full
    always_comb begin
        w_cap_eff = CMP_W'(r_cap);
        if (w_cap_eff == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (w_cap_eff > CMP_W'(ENTRIES)) begin
            w_cap_eff = CMP_W'(ENTRIES);
        end
    end

    assign w_full = (CMP_W'(r_occ) >= w_cap_eff);

    // target: hit position, first free position, or oldest position
    always_comb begin
        if (w_hit) begin
            w_target = w_hit_idx;
        end else if (w_full) begin
            w_target = IDX_W'(r_occ - CNT_W'(1));
        end else begin
            w_target = IDX_W'(r_occ);
        end
    end

    // request decode: status, result fields, new head entry
    always_comb begin
        n_rsp             = '0;
        n_occ             = r_occ;
        w_shift           = 1'b0;
        w_head_key        = r_req.key;
        w_head_value      = r_req.write_value;
        if (r_req.op == OP_GET) begin
            if (w_hit) begin
                n_rsp.status     = ST_GET_HIT;
                n_rsp.read_value = w_sel_value;
                w_head_key       = w_sel_key;
                w_head_value     = w_sel_value;
                w_shift          = 1'b1;
            end else begin
                n_rsp.status     = ST_GET_MISS;
                n_rsp.read_value = '1;
            end
        end else if (r_req.key[KEY_BITS-1]) begin
            n_rsp.status = ST_PUT_REJECTED;
        end else if (w_hit) begin
            n_rsp.status = ST_PUT_UPDATED;
            w_head_key   = w_sel_key;
            w_shift      = 1'b1;
        end else if (!w_full) begin
            n_rsp.status = ST_PUT_ADDED;
            n_occ        = r_occ + CNT_W'(1);
            w_shift      = 1'b1;
        end else begin
            n_rsp.status      = ST_PUT_REPLACED;
            n_rsp.evicted_key = w_sel_key;
            w_shift           = 1'b1;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (w_upd_go) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and response register
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
        if (w_upd_go) begin
            r_rsp <= n_rsp;
        end
    end

    // occupancy bounded by the chain length
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(ENTRIES))
        else $error("occupancy above entry count");

    // valid entries are packed at the newest end and counted by occupancy
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(c_valid) == int'(r_occ))
        else $error("valid entries disagree with occupancy");

    // stored keys are unique, so at most one cell matches
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(c_match))
        else $error("more than one cell matched the key");

    // an update always leaves a result waiting
    a_upd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_go |=> (r_out_valid && r_state == S_IDLE))
        else $error("update step did not post a result");

endmodule

// ----- sv/lkvc_cell.sv -----
// lkvc_cell: one position of the recency-ordered entry chain
// holds valid, key and value; loads its newer neighbor on a shift
// depends on lkvc_pkg
`timescale 1ns / 1ps

module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctrl             i_ctrl,
    input  logic [KEY_BITS-1:0]    i_req_key,
    input  logic [IDX_W-1:0]       i_target,
    input  logic                   i_prev_valid,
    input  logic [KEY_BITS-1:0]    i_prev_key,
    input  logic [VALUE_BITS-1:0]  i_prev_value,
    output logic                   o_valid,
    output logic [KEY_BITS-1:0]    o_key,
    output logic [VALUE_BITS-1:0]  o_value,
    output logic                   o_match,
    output logic                   o_sel
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_match;
    logic                  w_load;

    // this position takes part in the shift when it lies at or before the target
    assign w_load = i_ctrl.upd_en && (MY_IDX <= i_target);

    // valid bit and match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= i_prev_valid;
            end
            if (i_ctrl.cmp_en) begin
                r_match <= r_valid && (r_key == i_req_key);
            end
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_match;
    assign o_sel   = (MY_IDX == i_target);

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench for lru_key_value_cache_top
// predicts every response with an lru table of its own, checks each transfer
// depends on lkvc_pkg and the cache rtl
`timescale 1ns / 1ps

module tb_top;
    import lkvc_pkg::*;

    localparam int ENTRIES       = 16;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int POOL_MAX      = 24;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CAP_BITS-1:0]  i_cfg_wr_data;
    logic                 i_valid;
    logic                 o_ready;
    t_req                 i_req;
    logic                 o_valid;
    logic                 i_ready;
    t_rsp                 o_rsp;

    // predicted table state
    bit                           cache_valid [ENTRIES];
    logic signed [KEY_BITS-1:0]   cache_key   [ENTRIES];
    logic signed [VALUE_BITS-1:0] cache_value [ENTRIES];
    int                           cache_rank  [ENTRIES];
    int                           cache_fill = 0;
    logic [CAP_BITS-1:0]          cap_reg = CAP_RESET;

    // responses still owed by the block, oldest first
    t_rsp rsp_due [$];
    t_rsp head_rsp;

    // keys drawn by random traffic so that hits and replacements happen
    logic signed [KEY_BITS-1:0] key_pool [POOL_MAX];
    int pool_n = 1;

    int  errors = 0;
    int  cycle_cnt = 0;
    int  ready_hold = 0;
    bit  calm = 1'b0;

    lru_key_value_cache_top #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req        (i_req),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_rsp        (o_rsp)
    );

    // clock
    always #(CLK_HALF) i_clk = ~i_clk;

    // move an entry to newest; entries that were newer age by one
    function automatic void make_newest(int idx);
        int r;
        int i;
        r = cache_rank[idx];
        for (i = 0; i < ENTRIES; i++)
            if (cache_valid[i] && i != idx && cache_rank[i] < r)
                cache_rank[i]++;
        cache_rank[idx] = 0;
    endfunction

    function automatic int oldest_entry();
        int best;
        int i;
        best = -1;
        for (i = 0; i < ENTRIES; i++)
            if (cache_valid[i] && (best < 0 || cache_rank[i] > cache_rank[best]))
                best = i;
        return best;
    endfunction

    // apply one request to the predicted table and return its response
    function automatic t_rsp lru_access(t_req r);
        t_rsp res;
        int   hit;
        int   slot;
        int   eff_cap;
        int   i;
        res.status      = ST_GET_MISS;
        res.read_value  = '0;
        res.evicted_key = '0;
        hit  = -1;
        slot = -1;
        for (i = 0; i < ENTRIES; i++)
            if (hit < 0 && cache_valid[i] && cache_key[i] == r.key)
                hit = i;
        // capacity zero acts as one, anything above the table acts as the table
        eff_cap = int'(cap_reg);
        if (eff_cap < 1) eff_cap = 1;
        if (eff_cap > ENTRIES) eff_cap = ENTRIES;

        if (r.op == OP_GET) begin
            if (hit >= 0) begin
                make_newest(hit);
                res.read_value = cache_value[hit];
                res.status     = ST_GET_HIT;
            end else begin
                res.read_value = '1;
                res.status     = ST_GET_MISS;
            end
        end else if (r.key[KEY_BITS-1]) begin
            res.status = ST_PUT_REJECTED;
        end else if (hit >= 0) begin
            cache_value[hit] = r.write_value;
            make_newest(hit);
            res.status = ST_PUT_UPDATED;
        end else if (cache_fill < eff_cap) begin
            for (i = ENTRIES - 1; i >= 0; i--)
                if (!cache_valid[i]) slot = i;
            for (i = 0; i < ENTRIES; i++)
                if (cache_valid[i]) cache_rank[i]++;
            cache_valid[slot] = 1'b1;
            cache_key[slot]   = r.key;
            cache_value[slot] = r.write_value;
            cache_rank[slot]  = 0;
            cache_fill++;
            res.status = ST_PUT_ADDED;
        end else begin
            // full, or capacity lowered under the fill: replace the oldest
            slot = oldest_entry();
            res.evicted_key   = cache_key[slot];
            cache_key[slot]   = r.key;
            cache_value[slot] = r.write_value;
            make_newest(slot);
            res.status = ST_PUT_REPLACED;
        end
        return res;
    endfunction

    // predict on each accepted request, check each response transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                rsp_due.push_back(lru_access(i_req));
            if (o_valid && i_ready) begin
                if (rsp_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected response: status %0d read %0h evicted %0h",
                             $time, o_rsp.status, o_rsp.read_value, o_rsp.evicted_key);
                end else begin
                    head_rsp = rsp_due.pop_front();
                    if (o_rsp.status !== head_rsp.status) begin
                        errors++;
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, head_rsp.status, o_rsp.status);
                    end
                    if (o_rsp.read_value !== head_rsp.read_value) begin
                        errors++;
                        $display("%0t read_value mismatch: expected %0h actual %0h",
                                 $time, head_rsp.read_value, o_rsp.read_value);
                    end
                    if (o_rsp.evicted_key !== head_rsp.evicted_key) begin
                        errors++;
                        $display("%0t evicted_key mismatch: expected %0h actual %0h",
                                 $time, head_rsp.evicted_key, o_rsp.evicted_key);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // response side backpressure in random bursts
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm || $urandom_range(0, 2) != 0) begin
            i_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 15);
        end else begin
            i_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 6);
        end
    end

    // one request transfer; valid stays high on return
    task automatic send_req(input logic op, input logic signed [KEY_BITS-1:0] key,
                            input logic signed [VALUE_BITS-1:0] wval);
        t_req r;
        int   gap;
        r.op          = op;
        r.key         = key;
        r.write_value = wval;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // stop requests and wait until every response is back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cap_reg = cap;
    endtask

    function automatic logic signed [KEY_BITS-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            return key_pool[$urandom_range(0, pool_n - 1)];
        else if (sel == 8)
            return {1'b1, 31'($urandom)};
        else
            return $urandom;
    endfunction

    // lookups on an empty table, negative key lookup
    task automatic test_empty_table();
        send_req(OP_GET, 32'sh0000_0000, 32'sh1234_5678);
        send_req(OP_GET, 32'sh8000_0000, 32'sh0000_0000);
    endtask

    // extreme keys and values, rejected puts, hits and an update
    task automatic test_put_get();
        send_req(OP_PUT, 32'sh0000_0000, 32'sh8000_0000);
        send_req(OP_PUT, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_req(OP_PUT, 32'sh8000_0000, 32'sh0000_0001);
        send_req(OP_PUT, 32'shffff_ffff, 32'sh0000_0005);
        send_req(OP_GET, 32'sh7fff_ffff, 32'sh0000_0000);
        send_req(OP_GET, 32'sh0000_0000, 32'shffff_ffff);
        send_req(OP_PUT, 32'sh0000_0000, 32'shffff_ffff);
        send_req(OP_GET, 32'sh0000_0000, 32'sh0000_0000);
        send_req(OP_GET, 32'shffff_ffff, 32'sh0000_0000);
    endtask

    // small capacity: replacement of the oldest, recency refreshed by a get
    task automatic test_eviction();
        set_capacity(5'd2);
        send_req(OP_PUT, 32'sh0000_000a, 32'sh0000_0100);
        send_req(OP_GET, 32'sh0000_000a, 32'sh0000_0000);
        send_req(OP_PUT, 32'sh0000_000b, 32'sh0000_0200);
        send_req(OP_PUT, 32'sh0000_000c, 32'sh0000_0300);
    endtask

    // capacity zero acts as one and is below the fill; all ones clamps to the table
    task automatic test_capacity_clamp();
        set_capacity(5'd0);
        send_req(OP_PUT, 32'sh0000_0014, 32'sh5555_5555);
        send_req(OP_PUT, 32'sh0000_0015, 32'shaaaa_aaaa);
        set_capacity(5'd31);
        send_req(OP_PUT, 32'sh0000_001e, 32'sh0000_001e);
        send_req(OP_PUT, 32'sh0000_001f, 32'sh0000_001f);
        send_req(OP_GET, 32'sh0000_0014, 32'sh0000_0000);
    endtask

    // mixed gets and puts over a key pool sized near the capacity
    task automatic test_random_traffic(input int n, input logic [CAP_BITS-1:0] cap);
        int eff_cap;
        int i;
        set_capacity(cap);
        eff_cap = int'(cap);
        if (eff_cap < 1) eff_cap = 1;
        if (eff_cap > ENTRIES) eff_cap = ENTRIES;
        pool_n = eff_cap + $urandom_range(1, 6);
        if (pool_n > POOL_MAX) pool_n = POOL_MAX;
        for (i = 0; i < POOL_MAX; i++)
            key_pool[i] = {1'b0, 31'($urandom)};
        key_pool[$urandom_range(0, pool_n - 1)] = 32'sh0000_0000;
        key_pool[$urandom_range(0, pool_n - 1)] = 32'sh7fff_ffff;
        for (i = 0; i < n; i++)
            send_req(1'($urandom_range(0, 1)), pick_key(), $urandom);
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_req         = '0;
        i_ready       = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_put_get();
        test_eviction();
        test_capacity_clamp();

        test_random_traffic(200, 5'd16);
        test_random_traffic(200, 5'd1);
        test_random_traffic(200, 5'd2);
        test_random_traffic(200, 5'd3);
        test_random_traffic(200, 5'd8);
        test_random_traffic(200, 5'd0);
        test_random_traffic(200, 5'd31);
        test_random_traffic(200, 5'd5);
        calm = 1'b1;
        test_random_traffic(150, 5'd16);

        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
